// ===== src/kfg_pkg.sv =====
// Package for the keyframe gate: field widths, constants, sequencer opcodes.
// No dependencies.
`default_nettype none
package kfg_pkg;
	localparam int QFRAC = 14;
	localparam logic signed [15:0] QONE = 16'sd16384;

	localparam logic [1:0] REG_DIST  = 2'd0;
	localparam logic [1:0] REG_FRAME = 2'd1;
	localparam logic [1:0] REG_COS   = 2'd2;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pose_t;

	typedef struct packed {
		logic [15:0]        keyframe_index;
		logic               turn_triggered;
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [31:0] delta_z;
		logic signed [15:0] rel_x;
		logic signed [15:0] rel_y;
		logic signed [15:0] rel_z;
		logic signed [15:0] rel_w;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       step;
		logic [4:0] op;
		logic       commit;
	} kfg_cmd_t;

	typedef struct packed {
		logic fire;
	} kfg_sts_t;

	localparam logic [4:0] OP_SQ_X  = 5'd0;
	localparam logic [4:0] OP_SQ_Y  = 5'd1;
	localparam logic [4:0] OP_SQ_Z  = 5'd2;
	localparam logic [4:0] OP_DOT_X = 5'd3;
	localparam logic [4:0] OP_DOT_Y = 5'd4;
	localparam logic [4:0] OP_DOT_Z = 5'd5;
	localparam logic [4:0] OP_DOT_W = 5'd6;
	localparam logic [4:0] OP_UYY   = 5'd7;
	localparam logic [4:0] OP_UZZ   = 5'd8;
	localparam logic [4:0] OP_UXX   = 5'd9;
	localparam logic [4:0] OP_UXY   = 5'd10;
	localparam logic [4:0] OP_WUZ   = 5'd11;
	localparam logic [4:0] OP_UXZ   = 5'd12;
	localparam logic [4:0] OP_WUY   = 5'd13;
	localparam logic [4:0] OP_UYZ   = 5'd14;
	localparam logic [4:0] OP_WUX   = 5'd15;
	localparam logic [4:0] OP_REL   = 5'd16;
	localparam logic [4:0] OP_DX0   = 5'd17;
	localparam logic [4:0] OP_DX1   = 5'd18;
	localparam logic [4:0] OP_DX2   = 5'd19;
	localparam logic [4:0] OP_DY0   = 5'd20;
	localparam logic [4:0] OP_DY1   = 5'd21;
	localparam logic [4:0] OP_DY2   = 5'd22;
	localparam logic [4:0] OP_DZ0   = 5'd23;
	localparam logic [4:0] OP_DZ1   = 5'd24;
	localparam logic [4:0] OP_DZ2   = 5'd25;
endpackage
`default_nettype wire

// ===== src/kfg_if.sv =====
// Valid/ready channel interface for the keyframe gate.
// No package dependency; the payload type is a parameter.
`default_nettype none
interface kfg_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/keyframe_gate_relative_pose.sv =====
// Keyframe gate top level: config registers, sequencer and datapath.
// Depends on kfg_pkg, kfg_if, kfg_ctrl, kfg_datapath.
//
// Each pose steps through the shared multiplier sequence in the datapath; the
// sequence stops early when no keyframe results and runs to the end, followed
// by the output handshake, when one does. One pose is processed at a time.
`default_nettype none
module keyframe_gate_relative_pose #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kfg_if.sink       in_ch,
	kfg_if.sink       cfg_ch,
	kfg_if.source     out_ch
);
	import kfg_pkg::*;

	logic [30:0] dist_q;
	logic [15:0] frame_q;
	logic [14:0] cos_q;
	kfg_cmd_t    cmd;
	kfg_sts_t    sts;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= 31'd8192;
			frame_q <= 16'd10;
			cos_q   <= 15'd16057;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				REG_DIST:  dist_q  <= cfg_ch.data.data[30:0];
				REG_FRAME: frame_q <= cfg_ch.data.data[15:0];
				REG_COS:   cos_q   <= cfg_ch.data.data[14:0];
				default: ;
			endcase
		end
	end

	kfg_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	kfg_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk, .arst_n, .cmd, .pose(in_ch.data),
		.dist_th(dist_q), .frame_th(frame_q), .cos_half(cos_q),
		.sts, .result(out_ch.data)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
endmodule
`default_nettype wire

// ===== src/kfg_datapath.sv =====
// Datapath: one shared multiplier with accumulator stepping through the tests and deltas.
// Depends on kfg_pkg.
`default_nettype none
module kfg_datapath #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire kfg_pkg::kfg_cmd_t    cmd,
	input  wire kfg_pkg::pose_t       pose,
	input  wire logic [30:0]          dist_th,
	input  wire logic [15:0]          frame_th,
	input  wire logic [14:0]          cos_half,
	output kfg_pkg::kfg_sts_t         sts,
	output kfg_pkg::result_t          result
);
	import kfg_pkg::*;

	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	pose_t              in_q;
	logic signed [31:0] lp_q [3];
	logic signed [15:0] lq_q [4];
	logic [COUNT_BITS-1:0] frames_q, keys_q;
	logic signed [32:0] d_q [3];
	logic               far_q;
	logic [63:0]        sq_q;
	logic signed [33:0] acc_q;
	logic signed [17:0] r_q [9];
	logic signed [63:0] dacc_q;
	logic               dist_q, turn_q;
	result_t            res_q;

	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic signed [15:0] ux, uy, uz, w1;
	logic signed [15:0] q [4];
	logic [32:0] absd;
	logic signed [33:0] acc_n;
	logic signed [15:0] rnd16;
	logic signed [31:0] sat32;
	logic signed [63:0] dsum;

	assign ux = -lq_q[0];
	assign uy = -lq_q[1];
	assign uz = -lq_q[2];
	assign w1 = lq_q[3];
	assign q[0] = in_q.quat_x;
	assign q[1] = in_q.quat_y;
	assign q[2] = in_q.quat_z;
	assign q[3] = in_q.quat_w;

	function automatic logic signed [15:0] qround(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd8192) >>> QFRAC;
		if (t > 34'sd16384) return QONE;
		if (t < -34'sd16384) return -QONE;
		return t[15:0];
	endfunction

	function automatic logic signed [17:0] mround(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd8192) >>> QFRAC;
		return t[17:0];
	endfunction

	// Squared distance, dot product, rotation matrix, then one matrix-times-difference
	// product per step; the relative quaternion is computed outside this shared path.
	always_comb begin
		ma = '0;
		mb = '0;
		absd = '0;
		case (cmd.op) inside
			OP_SQ_X, OP_SQ_Y, OP_SQ_Z: begin
				absd = d_q[cmd.op[1:0]][32] ? 33'(-d_q[cmd.op[1:0]]) : 33'(d_q[cmd.op[1:0]]);
				ma = 34'(absd);
				mb = 34'(absd);
			end
			OP_DOT_X: begin ma = 34'(lq_q[0]); mb = 34'(q[0]); end
			OP_DOT_Y: begin ma = 34'(lq_q[1]); mb = 34'(q[1]); end
			OP_DOT_Z: begin ma = 34'(lq_q[2]); mb = 34'(q[2]); end
			OP_DOT_W: begin ma = 34'(lq_q[3]); mb = 34'(q[3]); end
			OP_UYY: begin ma = 34'(uy); mb = 34'(uy); end
			OP_UZZ: begin ma = 34'(uz); mb = 34'(uz); end
			OP_UXX: begin ma = 34'(ux); mb = 34'(ux); end
			OP_UXY: begin ma = 34'(ux); mb = 34'(uy); end
			OP_WUZ: begin ma = 34'(w1); mb = 34'(uz); end
			OP_UXZ: begin ma = 34'(ux); mb = 34'(uz); end
			OP_WUY: begin ma = 34'(w1); mb = 34'(uy); end
			OP_UYZ: begin ma = 34'(uy); mb = 34'(uz); end
			OP_WUX: begin ma = 34'(w1); mb = 34'(ux); end
			OP_DX0: begin ma = 34'(r_q[0]); mb = 34'(d_q[0]); end
			OP_DX1: begin ma = 34'(r_q[1]); mb = 34'(d_q[1]); end
			OP_DX2: begin ma = 34'(r_q[2]); mb = 34'(d_q[2]); end
			OP_DY0: begin ma = 34'(r_q[3]); mb = 34'(d_q[0]); end
			OP_DY1: begin ma = 34'(r_q[4]); mb = 34'(d_q[1]); end
			OP_DY2: begin ma = 34'(r_q[5]); mb = 34'(d_q[2]); end
			OP_DZ0: begin ma = 34'(r_q[6]); mb = 34'(d_q[0]); end
			OP_DZ1: begin ma = 34'(r_q[7]); mb = 34'(d_q[1]); end
			OP_DZ2: begin ma = 34'(r_q[8]); mb = 34'(d_q[2]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = ma * mb;

	logic signed [33:0] p34;
	assign p34 = prod[33:0];

	always_comb begin
		dsum = dacc_q + 64'(prod);
		dsum = (dsum + 64'sd8192) >>> QFRAC;
		if (dsum > 64'sd2147483647) sat32 = 32'h7fffffff;
		else if (dsum < -64'sd2147483648) sat32 = 32'h80000000;
		else sat32 = dsum[31:0];
	end

	logic signed [33:0] rel0, rel1, rel2, rel3;
	always_comb begin
		rel3 = 34'(w1)*34'(q[3]) + 34'(lq_q[0])*34'(q[0]) + 34'(lq_q[1])*34'(q[1])
			+ 34'(lq_q[2])*34'(q[2]);
		rel0 = 34'(w1)*34'(q[0]) - 34'(lq_q[0])*34'(q[3]) - 34'(lq_q[1])*34'(q[2])
			+ 34'(lq_q[2])*34'(q[1]);
		rel1 = 34'(w1)*34'(q[1]) + 34'(lq_q[0])*34'(q[2]) - 34'(lq_q[1])*34'(q[3])
			- 34'(lq_q[2])*34'(q[0]);
		rel2 = 34'(w1)*34'(q[2]) - 34'(lq_q[0])*34'(q[1]) + 34'(lq_q[1])*34'(q[0])
			- 34'(lq_q[2])*34'(q[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q[0] <= '0; lp_q[1] <= '0; lp_q[2] <= '0;
			lq_q[0] <= '0; lq_q[1] <= '0; lq_q[2] <= '0; lq_q[3] <= QONE;
			frames_q <= '0;
			keys_q <= '0;
			dist_q <= 1'b0;
			turn_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (frames_q != CMAX) frames_q <= frames_q + 1'b1;
			end
			if (cmd.step) begin
				if (cmd.op == OP_DOT_W) begin
					dist_q <= (far_q || sq_q > 64'(dist_th) * 64'(dist_th))
						&& (32'(frames_q) > 32'(frame_th));
					turn_q <= ((acc_q + p34) < 0 ? -(acc_q + p34) : (acc_q + p34))
						< 34'(cos_half) * 34'sd16384;
				end
			end
			if (cmd.commit) begin
				lp_q[0] <= in_q.pos_x; lp_q[1] <= in_q.pos_y; lp_q[2] <= in_q.pos_z;
				lq_q[0] <= q[0]; lq_q[1] <= q[1]; lq_q[2] <= q[2]; lq_q[3] <= q[3];
				frames_q <= '0;
				if (keys_q != CMAX) keys_q <= keys_q + 1'b1;
			end
		end
	end

	logic [COUNT_BITS-1:0] keys_n;
	assign keys_n = (keys_q != CMAX) ? keys_q + 1'b1 : keys_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q  <= pose;
			d_q[0] <= 33'(lp_q[0]) - 33'(pose.pos_x);
			d_q[1] <= 33'(lp_q[1]) - 33'(pose.pos_y);
			d_q[2] <= 33'(lp_q[2]) - 33'(pose.pos_z);
			far_q <= 1'b0;
			sq_q  <= '0;
			acc_q <= '0;
			dacc_q <= '0;
		end else if (cmd.step) begin
			case (cmd.op) inside
				OP_SQ_X, OP_SQ_Y, OP_SQ_Z: begin
					if (absd[32] || absd[31]) far_q <= 1'b1;
					else sq_q <= sq_q + 64'(prod[63:0]);
				end
				OP_DOT_X, OP_DOT_Y, OP_DOT_Z: acc_q <= acc_q + p34;
				OP_DOT_W: acc_q <= '0;
				OP_UYY: acc_q <= p34;
				OP_UZZ: begin
					r_q[0] <= mround(34'sd268435456 - 34'sd2 * (acc_q + p34));
				end
				OP_UXX: begin
					acc_q <= p34;
					r_q[4] <= mround(34'sd268435456 - 34'sd2 * (p34 + 34'(uz)*34'(uz)));
				end
				OP_UXY: begin
					r_q[8] <= mround(34'sd268435456 - 34'sd2 * (acc_q + 34'(uy)*34'(uy)));
					acc_q <= p34;
				end
				OP_WUZ: begin
					r_q[1] <= mround(34'sd2 * (acc_q - p34));
					r_q[3] <= mround(34'sd2 * (acc_q + p34));
				end
				OP_UXZ: acc_q <= p34;
				OP_WUY: begin
					r_q[2] <= mround(34'sd2 * (acc_q + p34));
					r_q[6] <= mround(34'sd2 * (acc_q - p34));
				end
				OP_UYZ: acc_q <= p34;
				OP_WUX: begin
					r_q[5] <= mround(34'sd2 * (acc_q - p34));
					r_q[7] <= mround(34'sd2 * (acc_q + p34));
				end
				OP_REL: begin
					res_q.rel_x <= qround(rel0);
					res_q.rel_y <= qround(rel1);
					res_q.rel_z <= qround(rel2);
					res_q.rel_w <= qround(rel3);
					res_q.turn_triggered <= turn_q;
					res_q.keyframe_index <= 16'(keys_n);
				end
				OP_DX0, OP_DY0, OP_DZ0: dacc_q <= 64'(prod);
				OP_DX1, OP_DY1, OP_DZ1: dacc_q <= dacc_q + 64'(prod);
				OP_DX2: res_q.delta_x <= sat32;
				OP_DY2: res_q.delta_y <= sat32;
				OP_DZ2: res_q.delta_z <= sat32;
				default: ;
			endcase
		end
	end

	assign sts.fire = dist_q | turn_q;
	assign result = res_q;
endmodule
`default_nettype wire

// ===== src/kfg_ctrl.sv =====
// Sequencer for the keyframe gate: accepts a pose, steps datapath ops, hands off the result.
// Depends on kfg_pkg.
`default_nettype none
module kfg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire kfg_pkg::kfg_sts_t sts,
	output kfg_pkg::kfg_cmd_t      cmd
);
	import kfg_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [4:0] op_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.load   = in_valid && in_ready;
		cmd.step   = (state_q == S_RUN);
		cmd.op     = op_q;
		cmd.commit = (state_q == S_RUN) && (op_q == OP_DZ2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						op_q <= OP_SQ_X;
					end
				end
				S_RUN: begin
					if (op_q == OP_UYY && !sts.fire) state_q <= S_IDLE;
					else if (op_q == OP_DZ2) state_q <= S_OUT;
					else op_q <= op_q + 5'd1;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
